// ===== rtl/rate_scaled_vblank_clock_macros.svh =====
// ----------------------------------------------------------------------------
// Rate-scaled VBlank clock: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef RATE_SCALED_VBLANK_CLOCK_MACROS_SVH
`define RATE_SCALED_VBLANK_CLOCK_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RSVC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rate_scaled_vblank_clock: assertion failed");

// Next-cycle implication, disabled during reset
`define RSVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rate_scaled_vblank_clock: assertion failed");

`endif

// ===== rtl/rsvc_pkg.sv =====
// ----------------------------------------------------------------------------
// Rate-scaled VBlank clock: package
// Payload types, register indexes and constants of the block.
// ----------------------------------------------------------------------------
package rsvc_pkg;

   // Parameter defaults
   localparam int TIME_WIDTH_DEF      = 48;
   localparam int MAX_LAG_PERIODS_DEF = 4;

   // Field widths
   localparam int FIELD_TIME_W = 48;
   localparam int COUNT_W      = 32;
   localparam int DELIVER_W    = 3;
   localparam int RATE_W       = 10;
   localparam int PERIOD_W     = 16;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE   = 2'd2;

   // Stall limits (fit in ELAPSED_W bits)
   localparam int ELAPSED_W = 19;
   localparam logic [ELAPSED_W-1:0] STALL_COOP_US = 19'd500000;
   localparam logic [ELAPSED_W-1:0] STALL_IRQ_US  = 19'd100000;

   // Rate clamp values
   localparam logic signed [RATE_W-1:0] RATE_DEFAULT = 10'sd100;
   localparam logic signed [RATE_W-1:0] RATE_MIN_RUN = 10'sd25;
   localparam logic signed [RATE_W-1:0] RATE_MAX     = 10'sd400;
   localparam logic signed [RATE_W-1:0] RATE_UNCAPPED = -10'sd1;
   localparam logic [PERIOD_W-1:0] PERIOD_DEFAULT = 16'd16683;

   // Scaling: elapsed (19 b) times rate magnitude (9 b), then divide by 100
   localparam int RATE_MAG_W = 9;
   localparam int PROD_W     = ELAPSED_W + RATE_MAG_W;
   localparam int QUOT_W     = 21;
   localparam int RECIP_W    = 29;
   localparam int RECIP_SHIFT = 35;
   // ceil(2^35 / 100); exact for every dividend below 2^28
   localparam logic [RECIP_W-1:0] RECIP_100 = 29'd343597384;
   localparam int RECIP_FULL_W = PROD_W + RECIP_W;

   typedef struct packed {
      logic [FIELD_TIME_W-1:0] real_time_us;
      logic                    step_request;
   } req_type;

   typedef struct packed {
      logic [FIELD_TIME_W-1:0] virtual_time_us;
      logic [FIELD_TIME_W-1:0] real_time_echo_us;
      logic [DELIVER_W-1:0]    vblanks_delivered;
      logic [COUNT_W-1:0]      vblank_total;
      logic                    stall_discarded;
   } rsp_type;

endpackage

// ===== rtl/rate_scaled_vblank_clock.sv =====
// ----------------------------------------------------------------------------
// Rate-scaled VBlank clock
// Scales host real time into a virtual clock and raises due VBlank events.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one real-time sample in microseconds and
//   an optional single-frame step request. rsp channel returns exactly one
//   result per sample: virtual time, echoed real time, VBlanks raised in this
//   step, running VBlank total and a stall flag.
//   csr port writes rate (index 0), VBlank period (index 1) and cooperative
//   mode (index 2) with no wait; write only while the block is idle.
// Sequence:
//   A sample runs through a small sequencer: elapsed time, stall check, one
//   multiply by the rate, one reciprocal multiply for the /100, the clock
//   advance, deadline set-up, then one check/lag pair per VBlank raised
//   through the deadline register, at most MAX_LAG_PERIODS + 2 of them. The
//   next sample is taken only after the result register has been loaded,
//   so the block finishes one sample before it takes the next.
// Reset clears the clock state and the result register and restores the
// register defaults. A stalled receiver holds the result register; the block
// takes the next sample meanwhile and waits at its end until the register
// is free.
// ----------------------------------------------------------------------------
module rate_scaled_vblank_clock #(
   parameter int TIME_WIDTH      = rsvc_pkg::TIME_WIDTH_DEF,
   parameter int MAX_LAG_PERIODS = rsvc_pkg::MAX_LAG_PERIODS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  rsvc_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output rsvc_pkg::rsp_type                  rsp_data,
   input  logic                               csr_we,
   input  logic [rsvc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rsvc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int LAG_W    = rsvc_pkg::PERIOD_W + $clog2(MAX_LAG_PERIODS + 1);
   localparam int DLV_W    = $clog2(MAX_LAG_PERIODS + 4);
   localparam int ITER_MAX = MAX_LAG_PERIODS + 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ELAPSED,
      ST_STALL,
      ST_SCALE,
      ST_RECIP,
      ST_ADVANCE,
      ST_INIT,
      ST_CHECK,
      ST_LAG,
      ST_DONE
   } state_type;

   // Configuration registers
   logic signed [rsvc_pkg::RATE_W-1:0]   rate_ff;
   logic [rsvc_pkg::PERIOD_W-1:0]        period_ff;
   logic                                 coop_ff;
   logic signed [rsvc_pkg::RATE_W-1:0]   rate_raw;
   logic signed [rsvc_pkg::RATE_W-1:0]   rate_in;

   // Sequencer and clock state
   state_type                            state_ff;
   logic [TIME_WIDTH-1:0]                real_ff;
   logic                                 step_ff;
   logic [TIME_WIDTH-1:0]                last_ff;
   logic [TIME_WIDTH-1:0]                virtual_ff;
   logic [TIME_WIDTH-1:0]                deadline_ff;
   logic [rsvc_pkg::COUNT_W-1:0]         counter_ff;
   logic [TIME_WIDTH-1:0]                elapsed_ff;
   logic                                 stall_ff;
   logic [rsvc_pkg::ELAPSED_W-1:0]       ela_ff;
   logic [rsvc_pkg::PROD_W-1:0]          prod_ff;
   logic [rsvc_pkg::QUOT_W-1:0]          quot_ff;
   logic [LAG_W-1:0]                     lag_ff;
   logic [DLV_W-1:0]                     dlv_ff;
   logic                                 rsp_valid_ff;
   rsvc_pkg::rsp_type                    rsp_data_ff;

   // Datapath helpers
   logic [rsvc_pkg::RECIP_FULL_W-1:0]    recip_full;
   logic [rsvc_pkg::ELAPSED_W-1:0]       limit;
   logic [DLV_W-1:0]                     dlv_final;
   logic [rsvc_pkg::COUNT_W-1:0]         counter_final;
   logic [TIME_WIDTH-1:0]                lag_mark;
   logic                                 rsp_load;

   // Clamp a rate write to -1, 0 or 25..400
   assign rate_raw = csr_wdata[rsvc_pkg::RATE_W-1:0];
   always_comb begin
      rate_in = rate_raw;
      if (rate_raw < rsvc_pkg::RATE_UNCAPPED) begin
         rate_in = rsvc_pkg::RATE_UNCAPPED;
      end else if (rate_raw > rsvc_pkg::RATE_MAX) begin
         rate_in = rsvc_pkg::RATE_MAX;
      end else if (rate_raw > 10'sd0 && rate_raw < rsvc_pkg::RATE_MIN_RUN) begin
         rate_in = rsvc_pkg::RATE_MIN_RUN;
      end
   end

   // Decode register writes; unknown index and zero period are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= rsvc_pkg::RATE_DEFAULT;
         period_ff <= rsvc_pkg::PERIOD_DEFAULT;
         coop_ff   <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            rsvc_pkg::CSR_RATE: begin
               rate_ff <= rate_in;
            end
            rsvc_pkg::CSR_PERIOD: begin
               if (csr_wdata != '0) begin
                  period_ff <= csr_wdata[rsvc_pkg::PERIOD_W-1:0];
               end
            end
            rsvc_pkg::CSR_MODE: begin
               coop_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Divide by 100 through the reciprocal
   assign recip_full = rsvc_pkg::RECIP_FULL_W'(prod_ff)
                     * rsvc_pkg::RECIP_FULL_W'(rsvc_pkg::RECIP_100);

   assign limit         = coop_ff ? rsvc_pkg::STALL_COOP_US : rsvc_pkg::STALL_IRQ_US;
   assign dlv_final     = dlv_ff + DLV_W'(step_ff);
   assign counter_final = counter_ff + rsvc_pkg::COUNT_W'(step_ff);
   assign lag_mark      = deadline_ff + TIME_WIDTH'(lag_ff);

   // Load the result register when the sequence ends and the register is free
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer, clock state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         last_ff      <= '0;
         virtual_ff   <= '0;
         deadline_ff  <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         // hold the result until it has been transferred
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  real_ff  <= TIME_WIDTH'(req_data.real_time_us);
                  step_ff  <= req_data.step_request;
                  state_ff <= ST_ELAPSED;
               end
            end
            ST_ELAPSED: begin
               // no previous sample means no elapsed time
               elapsed_ff <= (last_ff != '0) ? real_ff - last_ff : '0;
               last_ff    <= real_ff;
               state_ff   <= ST_STALL;
            end
            ST_STALL: begin
               if (elapsed_ff > TIME_WIDTH'(limit)) begin
                  stall_ff <= 1'b1;
                  ela_ff   <= '0;
               end else begin
                  stall_ff <= 1'b0;
                  ela_ff   <= elapsed_ff[rsvc_pkg::ELAPSED_W-1:0];
               end
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               prod_ff  <= rsvc_pkg::PROD_W'(ela_ff)
                         * rsvc_pkg::PROD_W'(rate_ff[rsvc_pkg::RATE_MAG_W-1:0]);
               state_ff <= ST_RECIP;
            end
            ST_RECIP: begin
               quot_ff  <= recip_full[rsvc_pkg::RECIP_SHIFT +: rsvc_pkg::QUOT_W];
               state_ff <= ST_ADVANCE;
            end
            ST_ADVANCE: begin
               // paused rate leaves the clock where it is
               if (rate_ff > 10'sd0) begin
                  virtual_ff <= virtual_ff + TIME_WIDTH'(quot_ff);
               end else if (rate_ff == rsvc_pkg::RATE_UNCAPPED) begin
                  virtual_ff <= virtual_ff + TIME_WIDTH'(ela_ff);
               end
               state_ff <= ST_INIT;
            end
            ST_INIT: begin
               // an unset deadline starts at the current virtual time
               if (deadline_ff == '0) begin
                  deadline_ff <= virtual_ff;
               end
               lag_ff   <= LAG_W'(period_ff * MAX_LAG_PERIODS);
               dlv_ff   <= '0;
               state_ff <= ST_CHECK;
            end
            ST_CHECK: begin
               if (virtual_ff >= deadline_ff && dlv_ff < DLV_W'(ITER_MAX)) begin
                  deadline_ff <= deadline_ff + TIME_WIDTH'(period_ff);
                  counter_ff  <= counter_ff + rsvc_pkg::COUNT_W'(1);
                  dlv_ff      <= dlv_ff + DLV_W'(1);
                  state_ff    <= ST_LAG;
               end else begin
                  state_ff <= ST_DONE;
               end
            end
            ST_LAG: begin
               // too far behind: jump the deadline to the virtual clock
               if (virtual_ff > lag_mark) begin
                  deadline_ff <= virtual_ff;
               end
               state_ff <= ST_CHECK;
            end
            ST_DONE: begin
               if (rsp_load) begin
                  counter_ff <= counter_final;
                  rsp_data_ff.virtual_time_us   <= rsvc_pkg::FIELD_TIME_W'(virtual_ff);
                  rsp_data_ff.real_time_echo_us <= rsvc_pkg::FIELD_TIME_W'(real_ff);
                  rsp_data_ff.vblanks_delivered <= (dlv_final > DLV_W'(7)) ?
                     rsvc_pkg::DELIVER_W'(7) : rsvc_pkg::DELIVER_W'(dlv_final);
                  rsp_data_ff.vblank_total      <= counter_final;
                  rsp_data_ff.stall_discarded   <= stall_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/rsvc_checker.sv =====
// ----------------------------------------------------------------------------
// Rate-scaled VBlank clock: port checker
// Watches the top level's channels and is bound to every instance.
// ----------------------------------------------------------------------------
`include "rate_scaled_vblank_clock_macros.svh"

module rsvc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input rsvc_pkg::rsp_type rsp_data
);

   // Hold a stalled result unchanged
   `RSVC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // Take one sample at a time: busy right after a transfer
   `RSVC_ASSERT_NEXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready)

   // A new result only comes out of a busy sequencer
   `RSVC_ASSERT_IMPL(a_rsp_from_busy, clock, reset, $rose(rsp_valid), !$past(req_ready))

endmodule

bind rate_scaled_vblank_clock rsvc_checker u_rsvc_checker (.*);
